[hdl/tree_lca_binary_lifting_defines.svh]
// Assertion helpers used by the top-level design file.
`ifndef TREE_LCA_BINARY_LIFTING_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define TLCA_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define TLCA_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TLCA_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tlca_pkg.sv]
package tlca_pkg;

    localparam int DATA_W = 10;
    localparam int LVL_W  = 5;
    localparam int UPC_W  = 5;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_BUILD = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [UPC_W-1:0] UPC_FETCH = 5'd0;
    localparam logic [UPC_W-1:0] UPC_Q0    = 5'd1;
    localparam logic [UPC_W-1:0] UPC_Q1    = 5'd2;
    localparam logic [UPC_W-1:0] UPC_Q2    = 5'd3;
    localparam logic [UPC_W-1:0] UPC_L0    = 5'd4;
    localparam logic [UPC_W-1:0] UPC_L1    = 5'd5;
    localparam logic [UPC_W-1:0] UPC_L2    = 5'd6;
    localparam logic [UPC_W-1:0] UPC_LT    = 5'd7;
    localparam logic [UPC_W-1:0] UPC_EQ    = 5'd8;
    localparam logic [UPC_W-1:0] UPC_P0    = 5'd9;
    localparam logic [UPC_W-1:0] UPC_P1    = 5'd10;
    localparam logic [UPC_W-1:0] UPC_P2    = 5'd11;
    localparam logic [UPC_W-1:0] UPC_F0    = 5'd12;
    localparam logic [UPC_W-1:0] UPC_F1    = 5'd13;
    localparam logic [UPC_W-1:0] UPC_B0    = 5'd14;
    localparam logic [UPC_W-1:0] UPC_B1    = 5'd15;
    localparam logic [UPC_W-1:0] UPC_B2    = 5'd16;
    localparam logic [UPC_W-1:0] UPC_BE    = 5'd17;
    localparam logic [UPC_W-1:0] UPC_LAST  = 5'd17;

    typedef enum logic [2:0] {
        BR_NEXT, BR_JUMP, BR_DISPATCH, BR_COND, BR_LOOP, BR_EQ, BR_OUT, BR_BLOOP
    } t_br;

    typedef enum logic [2:0] {
        J_NONE, J_A_K, J_B_K, J_A_0, J_I_KM1, J_JQ_KM1
    } t_jsel;

    typedef enum logic [1:0] {
        D_NONE, D_A, D_B, D_JQ
    } t_dsel;

    typedef enum logic [2:0] {
        OP_NONE, OP_CAP_DA, OP_SWAP, OP_LIFT, OP_KTOP, OP_CAP_JA, OP_STEP2, OP_BWRITE
    } t_op;

    typedef enum logic {
        OSEL_A, OSEL_JQ
    } t_osel;

    typedef struct packed {
        t_br              br;
        t_jsel            jsel;
        t_dsel            dsel;
        t_op              op;
        t_osel            osel;
        logic [UPC_W-1:0] tgt;
    } t_uword;

    typedef struct packed {
        logic              jre;
        logic [DATA_W-1:0] jr_node;
        logic [LVL_W-1:0]  jr_lvl;
        logic              jwe;
        logic [DATA_W-1:0] jw_node;
        logic [LVL_W-1:0]  jw_lvl;
        logic [DATA_W-1:0] jw_data;
        logic              dre;
        logic [DATA_W-1:0] dr_node;
        logic              dwe;
        logic [DATA_W-1:0] dw_node;
        logic [DATA_W-1:0] dw_data;
    } t_store_req;

    function automatic t_uword ucode(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '{br: BR_NEXT, jsel: J_NONE, dsel: D_NONE, op: OP_NONE,
              osel: OSEL_A, tgt: UPC_FETCH};
        unique case (pc)
            UPC_FETCH: w.br = BR_DISPATCH;
            UPC_Q0: w.dsel = D_A;
            UPC_Q1: begin
                w.op   = OP_CAP_DA;
                w.dsel = D_B;
            end
            UPC_Q2: w.op = OP_SWAP;
            UPC_L0: begin
                w.jsel = J_A_K;
                w.br   = BR_COND;
                w.tgt  = UPC_LT;
            end
            UPC_L1: begin
                w.op   = OP_LIFT;
                w.dsel = D_JQ;
            end
            UPC_L2: w.op = OP_CAP_DA;
            UPC_LT: begin
                w.br  = BR_LOOP;
                w.tgt = UPC_L0;
            end
            UPC_EQ: begin
                w.br = BR_EQ;
                w.op = OP_KTOP;
            end
            UPC_P0: w.jsel = J_A_K;
            UPC_P1: begin
                w.op   = OP_CAP_JA;
                w.jsel = J_B_K;
            end
            UPC_P2: begin
                w.op  = OP_STEP2;
                w.br  = BR_LOOP;
                w.tgt = UPC_P0;
            end
            UPC_F0: w.jsel = J_A_0;
            UPC_F1: begin
                w.br   = BR_OUT;
                w.osel = OSEL_JQ;
            end
            UPC_B0: w.jsel = J_I_KM1;
            UPC_B1: w.jsel = J_JQ_KM1;
            UPC_B2: begin
                w.op  = OP_BWRITE;
                w.br  = BR_BLOOP;
                w.tgt = UPC_B0;
            end
            UPC_BE: w.br = BR_JUMP;
            default: w.br = BR_JUMP;
        endcase
        return w;
    endfunction

endpackage

[hdl/tlca_store.sv]
module tlca_store #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tlca_pkg::t_store_req            i_req,
    output logic [tlca_pkg::DATA_W-1:0]     o_jq,
    output logic [tlca_pkg::DATA_W-1:0]     o_dq,
    output logic                            o_busy
);

    localparam int JDEPTH = MAX_NODES * LEVELS;
    localparam int AW     = $clog2(JDEPTH);
    localparam int DAW    = $clog2(MAX_NODES);

    logic [tlca_pkg::DATA_W-1:0] mem_jump  [JDEPTH];
    logic [tlca_pkg::DATA_W-1:0] mem_depth [MAX_NODES];

    logic                        r_clr_busy;
    logic [AW-1:0]               r_clr_addr;
    logic [tlca_pkg::DATA_W-1:0] r_jq;
    logic [tlca_pkg::DATA_W-1:0] r_dq;

    logic                        w_jwe;
    logic [AW-1:0]               w_jwa;
    logic [tlca_pkg::DATA_W-1:0] w_jwd;
    logic [AW-1:0]               w_jra;
    logic                        w_dwe;
    logic [DAW-1:0]              w_dwa;
    logic [tlca_pkg::DATA_W-1:0] w_dwd;
    logic [DAW-1:0]              w_dra;

    always_comb begin
        w_jra = AW'(AW'(i_req.jr_lvl) * AW'(MAX_NODES) + AW'(i_req.jr_node));
        w_dra = DAW'(i_req.dr_node);
        if (r_clr_busy) begin
            w_jwe = 1'b1;
            w_jwa = r_clr_addr;
            w_jwd = '0;
            w_dwe = (r_clr_addr < AW'(MAX_NODES));
            w_dwa = DAW'(r_clr_addr);
            w_dwd = '0;
        end else begin
            w_jwe = i_req.jwe;
            w_jwa = AW'(AW'(i_req.jw_lvl) * AW'(MAX_NODES) + AW'(i_req.jw_node));
            w_jwd = i_req.jw_data;
            w_dwe = i_req.dwe;
            w_dwa = DAW'(i_req.dw_node);
            w_dwd = i_req.dw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(JDEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_jwe) begin
            mem_jump[w_jwa] <= w_jwd;
        end
        if (i_req.jre) begin
            r_jq <= mem_jump[w_jra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dwe) begin
            mem_depth[w_dwa] <= w_dwd;
        end
        if (i_req.dre) begin
            r_dq <= mem_depth[w_dra];
        end
    end

    assign o_jq   = r_jq;
    assign o_dq   = r_dq;
    assign o_busy = r_clr_busy;

endmodule

[hdl/tree_lca_binary_lifting.sv]
// Channel     Dir  Handshake                          Payload
// s_axis      in   i_s_axis_tvalid / o_s_axis_tready  tuser action, tdata node fields
// m_axis      out  o_m_axis_tvalid / i_m_axis_tready  tdata ancestor
// cfg         in   i_cfg_valid / o_cfg_ready          node_count
//
// A load is written into the tables as it is accepted; builds and queries step
// through microcode whose steps wait on the registered reads of the table memories.
// After reset a clearing pass zeroes both tables, and no word is accepted until it
// ends. A finished result waits in the output register, and a second result stalls
// the sequencer until the first one is taken.
module tree_lca_binary_lifting #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: node, parent_node, node_level, other_node.
    input  logic [39:0] i_s_axis_tdata,
    // Fields from bit 0: action.
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: ancestor, then zero fill.
    output logic [15:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data
);

`include "tree_lca_binary_lifting_defines.svh"

    localparam int DW = tlca_pkg::DATA_W;
    localparam int LW = tlca_pkg::LVL_W;
    localparam int CW = ((LEVELS > DW) ? LEVELS : DW) + 1;
    localparam logic [LW-1:0] KTOP = LW'(LEVELS - 1);

    logic [tlca_pkg::UPC_W-1:0] r_pc;
    logic [DW-1:0]              r_a;
    logic [DW-1:0]              r_b;
    logic [DW-1:0]              r_da;
    logic [DW-1:0]              r_db;
    logic [DW-1:0]              r_ja;
    logic [LW-1:0]              r_k;
    logic [DW-1:0]              r_i;
    logic [DW-1:0]              r_last;
    logic [DW-1:0]              r_node_count;
    logic                       r_out_valid;
    logic [DW-1:0]              r_out_data;

    tlca_pkg::t_uword           w_uw;
    tlca_pkg::t_store_req       w_req;
    logic [DW-1:0]              w_jq;
    logic [DW-1:0]              w_dq;
    logic                       w_busy;
    logic                       w_acc;
    logic [DW-1:0]              w_node;
    logic [DW-1:0]              w_parent;
    logic [DW-1:0]              w_level;
    logic [DW-1:0]              w_other;
    logic [DW-1:0]              w_node_s;
    logic [DW-1:0]              w_other_s;
    logic [DW-1:0]              w_parent_s;
    logic [DW-1:0]              w_last;
    logic                       w_load_ok;
    logic [CW-1:0]              w_pow;
    logic                       w_lift;
    logic                       w_out_free;
    logic                       w_out_wr;
    logic                       w_step2;

    tlca_store #(
        .MAX_NODES (MAX_NODES),
        .LEVELS    (LEVELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_jq    (w_jq),
        .o_dq    (w_dq),
        .o_busy  (w_busy)
    );

    assign w_uw     = tlca_pkg::ucode(r_pc);
    assign w_node   = i_s_axis_tdata[9:0];
    assign w_parent = i_s_axis_tdata[19:10];
    assign w_level  = i_s_axis_tdata[29:20];
    assign w_other  = i_s_axis_tdata[39:30];

    assign o_s_axis_tready = (r_pc == tlca_pkg::UPC_FETCH) && !w_busy;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign w_node_s   = (32'(w_node) < MAX_NODES) ? w_node : '0;
    assign w_other_s  = (32'(w_other) < MAX_NODES) ? w_other : '0;
    assign w_parent_s = (32'(w_parent) < MAX_NODES) ? w_parent : '0;
    assign w_load_ok  = (w_node != '0) && (32'(w_node) < MAX_NODES);
    assign w_last     = (32'(r_node_count) > MAX_NODES - 1) ? DW'(MAX_NODES - 1)
                                                           : r_node_count;

    assign w_pow   = CW'(1) << r_k;
    assign w_lift  = CW'(r_da) >= (CW'(r_db) + w_pow);
    assign w_step2 = (r_ja != '0) && (w_jq != '0) && (r_ja != w_jq);

    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_out_wr   = w_out_free
                        && ((w_uw.br == tlca_pkg::BR_OUT)
                            || ((w_uw.br == tlca_pkg::BR_EQ) && (r_a == r_b)));

    always_comb begin
        w_req = '0;
        unique case (w_uw.jsel)
            tlca_pkg::J_NONE: ;
            tlca_pkg::J_A_K: begin
                w_req.jre     = 1'b1;
                w_req.jr_node = r_a;
                w_req.jr_lvl  = r_k;
            end
            tlca_pkg::J_B_K: begin
                w_req.jre     = 1'b1;
                w_req.jr_node = r_b;
                w_req.jr_lvl  = r_k;
            end
            tlca_pkg::J_A_0: begin
                w_req.jre     = 1'b1;
                w_req.jr_node = r_a;
            end
            tlca_pkg::J_I_KM1: begin
                w_req.jre     = 1'b1;
                w_req.jr_node = r_i;
                w_req.jr_lvl  = r_k - LW'(1);
            end
            tlca_pkg::J_JQ_KM1: begin
                w_req.jre     = 1'b1;
                w_req.jr_node = w_jq;
                w_req.jr_lvl  = r_k - LW'(1);
            end
            default: ;
        endcase
        unique case (w_uw.dsel)
            tlca_pkg::D_NONE: ;
            tlca_pkg::D_A: begin
                w_req.dre     = 1'b1;
                w_req.dr_node = r_a;
            end
            tlca_pkg::D_B: begin
                w_req.dre     = 1'b1;
                w_req.dr_node = r_b;
            end
            tlca_pkg::D_JQ: begin
                w_req.dre     = 1'b1;
                w_req.dr_node = w_jq;
            end
        endcase
        if (w_acc && (i_s_axis_tuser == tlca_pkg::ACT_LOAD) && w_load_ok) begin
            w_req.jwe     = 1'b1;
            w_req.jw_node = w_node;
            w_req.jw_lvl  = '0;
            w_req.jw_data = w_parent_s;
            w_req.dwe     = 1'b1;
            w_req.dw_node = w_node;
            w_req.dw_data = w_level;
        end else if (w_uw.op == tlca_pkg::OP_BWRITE) begin
            w_req.jwe     = 1'b1;
            w_req.jw_node = r_i;
            w_req.jw_lvl  = r_k;
            w_req.jw_data = w_jq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= tlca_pkg::UPC_FETCH;
            r_out_valid  <= 1'b0;
            r_node_count <= DW'(1);
        end else begin
            if (i_cfg_valid) begin
                r_node_count <= i_cfg_data;
            end

            if (w_out_wr) begin
                r_out_valid <= 1'b1;
                r_out_data  <= (w_uw.osel == tlca_pkg::OSEL_JQ) ? w_jq : r_a;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (w_uw.op)
                tlca_pkg::OP_NONE: ;
                tlca_pkg::OP_CAP_DA: r_da <= w_dq;
                tlca_pkg::OP_SWAP: begin
                    if (r_da < w_dq) begin
                        r_a  <= r_b;
                        r_b  <= r_a;
                        r_da <= w_dq;
                        r_db <= r_da;
                    end else begin
                        r_db <= w_dq;
                    end
                    r_k <= KTOP;
                end
                tlca_pkg::OP_LIFT: r_a <= w_jq;
                tlca_pkg::OP_KTOP: r_k <= KTOP;
                tlca_pkg::OP_CAP_JA: r_ja <= w_jq;
                tlca_pkg::OP_STEP2: begin
                    if (w_step2) begin
                        r_a <= r_ja;
                        r_b <= w_jq;
                    end
                end
                tlca_pkg::OP_BWRITE: ;
            endcase

            unique case (w_uw.br)
                tlca_pkg::BR_NEXT: r_pc <= r_pc + tlca_pkg::UPC_W'(1);
                tlca_pkg::BR_JUMP: r_pc <= w_uw.tgt;
                tlca_pkg::BR_DISPATCH: begin
                    if (w_acc) begin
                        unique case (i_s_axis_tuser)
                            tlca_pkg::ACT_BUILD: begin
                                if (w_last != '0) begin
                                    r_last <= w_last;
                                    r_i    <= DW'(1);
                                    r_k    <= LW'(1);
                                    r_pc   <= tlca_pkg::UPC_B0;
                                end
                            end
                            tlca_pkg::ACT_QUERY: begin
                                r_a  <= w_node_s;
                                r_b  <= w_other_s;
                                r_pc <= tlca_pkg::UPC_Q0;
                            end
                            default: ;
                        endcase
                    end
                end
                tlca_pkg::BR_COND: begin
                    r_pc <= w_lift ? (r_pc + tlca_pkg::UPC_W'(1)) : w_uw.tgt;
                end
                tlca_pkg::BR_LOOP: begin
                    if (r_k == '0) begin
                        r_pc <= r_pc + tlca_pkg::UPC_W'(1);
                    end else begin
                        r_k  <= r_k - LW'(1);
                        r_pc <= w_uw.tgt;
                    end
                end
                tlca_pkg::BR_EQ: begin
                    if (r_a == r_b) begin
                        if (w_out_free) begin
                            r_pc <= tlca_pkg::UPC_FETCH;
                        end
                    end else begin
                        r_pc <= r_pc + tlca_pkg::UPC_W'(1);
                    end
                end
                tlca_pkg::BR_OUT: begin
                    if (w_out_free) begin
                        r_pc <= tlca_pkg::UPC_FETCH;
                    end
                end
                tlca_pkg::BR_BLOOP: begin
                    if (r_i == r_last) begin
                        r_i <= DW'(1);
                        if (r_k == KTOP) begin
                            r_pc <= r_pc + tlca_pkg::UPC_W'(1);
                        end else begin
                            r_k  <= r_k + LW'(1);
                            r_pc <= w_uw.tgt;
                        end
                    end else begin
                        r_i  <= r_i + DW'(1);
                        r_pc <= w_uw.tgt;
                    end
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_data};
    assign o_cfg_ready     = i_rst_n;

    `TLCA_IMPLY(a_no_accept_in_clear, w_busy, !o_s_axis_tready, "word accepted during clear")
    `TLCA_CHECK(a_pc_in_program, r_pc <= tlca_pkg::UPC_LAST, "microcode counter out of program")
    `TLCA_IMPLY(a_build_index, r_pc == tlca_pkg::UPC_B0,
                (r_i != '0) && (r_i <= r_last), "build index out of range")
    `TLCA_NEXT(a_query_starts, w_acc && (i_s_axis_tuser == tlca_pkg::ACT_QUERY),
               r_pc == tlca_pkg::UPC_Q0, "query did not start")

endmodule
